@@ rtl/rie_pkg.sv @@
// Package for the integer subset executor: sizes, codes, ALU operations
// and the result word layout. No dependencies.
`timescale 1ns / 1ps

package rie_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int XLEN      = 32;

  // Command codes of an input word
  localparam logic [1:0] CMD_STEP    = 2'd0;
  localparam logic [1:0] CMD_LOAD    = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Status codes of a result word
  localparam logic [1:0] ST_EXEC    = 2'd0;
  localparam logic [1:0] ST_UNKNOWN = 2'd1;
  localparam logic [1:0] ST_LOADED  = 2'd2;
  localparam logic [1:0] ST_RESTART = 2'd3;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_XORI  = 6'd14;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // Function codes under the R-type opcode
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_NOR  = 6'd39;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_XOR, ALU_NOR,
    ALU_SLT, ALU_SLTU, ALU_SLL, ALU_SRL, ALU_LUI
  } alu_op_e;

  typedef struct packed {
    logic [1:0]      status;
    logic [XLEN-1:0] instruction;
    logic [XLEN-1:0] next_pc;
    logic            reg_written;
    logic [4:0]      reg_index;
    logic [XLEN-1:0] reg_value;
    logic            mem_written;
    logic [9:0]      mem_index;
    logic [XLEN-1:0] mem_value;
    logic            breakpoint_hit;
  } result_t;

  // Byte address to word index, wrapped to the memory size
  function automatic logic [MEM_AW-1:0] word_of(input logic [XLEN-1:0] addr);
    logic [XLEN-1:0] w;
    w = addr >> 2;
    return w[MEM_AW-1:0];
  endfunction

  // Word index as reported on the 10-bit result field
  function automatic logic [9:0] index_out(input logic [MEM_AW-1:0] idx);
    logic [XLEN-1:0] w;
    w = XLEN'(idx);
    return w[9:0];
  endfunction

endpackage

@@ rtl/rie_in_if.sv @@
// Input channel of the integer subset executor: command words.
// Depends on nothing.
`timescale 1ns / 1ps

interface rie_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [9:0]  load_address;
  logic [31:0] load_data;

  modport source (output valid, opcode, load_address, load_data, input ready);
  modport sink   (input valid, opcode, load_address, load_data, output ready);
endinterface

@@ rtl/rie_out_if.sv @@
// Output channel of the integer subset executor: result words.
// Depends on nothing.
`timescale 1ns / 1ps

interface rie_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] instruction;
  logic [31:0] next_pc;
  logic        reg_written;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        mem_written;
  logic [9:0]  mem_index;
  logic [31:0] mem_value;
  logic        breakpoint_hit;

  modport source (output valid, status, instruction, next_pc, reg_written, reg_index,
                  reg_value, mem_written, mem_index, mem_value, breakpoint_hit,
                  input ready);
  modport sink   (input valid, status, instruction, next_pc, reg_written, reg_index,
                  reg_value, mem_written, mem_index, mem_value, breakpoint_hit,
                  output ready);
endinterface

@@ rtl/rie_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module rie_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rie_alu.sv @@
// Shared ALU: add, subtract, logic, set-less-than, shifts and upper load.
// Depends on rie_pkg.
`timescale 1ns / 1ps

module rie_alu (
  input  rie_pkg::alu_op_e  op_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  input  logic [4:0]        sa_i,
  output logic [31:0]       y_o,
  output logic              zero_o
);

  // Select the operation
  always_comb begin
    case (op_i)
      rie_pkg::ALU_ADD:  y_o = a_i + b_i;
      rie_pkg::ALU_SUB:  y_o = a_i - b_i;
      rie_pkg::ALU_AND:  y_o = a_i & b_i;
      rie_pkg::ALU_OR:   y_o = a_i | b_i;
      rie_pkg::ALU_XOR:  y_o = a_i ^ b_i;
      rie_pkg::ALU_NOR:  y_o = ~(a_i | b_i);
      rie_pkg::ALU_SLT:  y_o = {31'd0, $signed(a_i) < $signed(b_i)};
      rie_pkg::ALU_SLTU: y_o = {31'd0, a_i < b_i};
      rie_pkg::ALU_SLL:  y_o = b_i << sa_i;
      rie_pkg::ALU_SRL:  y_o = b_i >> sa_i;
      rie_pkg::ALU_LUI:  y_o = {b_i[15:0], 16'd0};
      default:           y_o = '0;
    endcase
  end

  assign zero_o = (y_o == 32'd0);

endmodule

@@ rtl/risc_integer_subset_executor.sv @@
// Top level of the integer subset executor: sequencer, PC, register file
// and word memory. Depends on rie_pkg, rie_in_if, rie_out_if, rie_ram, rie_alu.
`timescale 1ns / 1ps

// Usage:
//   in_s carries command words (step, load memory word, restart); out_s
//   returns one result word per command. cfg_we_i/cfg_idx_i/cfg_data_i
//   write start_pc (index 0) and breakpoint_pc (index 1); the user must
//   write them only while idle; this is not enforced. One command is in
//   flight at a time; in_s.ready is high only when the sequencer is idle.
//   Sequence: load, restart and the unused command pass from acceptance
//   through the result register to the output register. A step runs
//   memory fetch, rs read, rt read and execute on the shared ALU, plus one
//   memory read for lw, then the output register. All of these go
//   through one read port of the word memory and of the register file.
//   Reset: the word memory is swept to zero, one word per cycle, over all
//   MEM_WORDS (1024) words; no command is taken during the sweep.
//   Registers and PC clear at once.
//   Stall: a result word holds on out_s until taken; the sequencer can
//   take the next command but waits in its output step until then.
module risc_integer_subset_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  rie_in_if.sink      in_s,
  rie_out_if.source   out_s,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_RDA   = 3'd3;
  localparam logic [2:0] S_RDB   = 3'd4;
  localparam logic [2:0] S_EXEC  = 3'd5;
  localparam logic [2:0] S_LWB   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_BREAK = 1'b1;

  logic [2:0]                   state_q, state_d;
  logic [rie_pkg::MEM_AW-1:0]   clr_q, clr_d;
  logic [31:0]                  pc_q, pc_d;
  logic [31:0]                  pc4_q, pc4_d;
  logic [31:0]                  ir_q, ir_d;
  logic [31:0]                  a_q, a_d;
  logic [31:0]                  b_q, b_d;
  logic [31:0]                  start_q, brk_q;
  logic [31:0]                  rf_vld_q, rf_vld_d;
  rie_pkg::result_t             res_q, res_d;
  rie_pkg::result_t             out_q, out_d;
  logic                         out_vld_q, out_vld_d;

  // Memory ports
  logic                         mem_we, mem_re;
  logic [rie_pkg::MEM_AW-1:0]   mem_waddr, mem_raddr;
  logic [31:0]                  mem_wdata, mem_rdata;
  logic                         rf_we, rf_re;
  logic [4:0]                   rf_waddr, rf_raddr;
  logic [31:0]                  rf_wdata, rf_rdata;

  // ALU
  rie_pkg::alu_op_e             alu_op;
  logic [31:0]                  alu_b, alu_y;
  logic                         alu_zero;

  // Instruction fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] sext, zext, br_tgt, j_tgt, ld_wide;
  logic [31:0] rd_val;
  logic [4:0]  rd_idx;
  logic        wr, known, is_lw, is_sw;
  logic [4:0]  wi;

  rie_ram #(.Width(32), .Depth(rie_pkg::MEM_WORDS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  rie_ram #(.Width(32), .Depth(32)) u_rf (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (rf_re),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  rie_alu u_alu (
    .op_i   (alu_op),
    .a_i    (a_q),
    .b_i    (alu_b),
    .sa_i   (sa),
    .y_o    (alu_y),
    .zero_o (alu_zero)
  );

  // Decode the held instruction
  assign op      = ir_q[31:26];
  assign fn      = ir_q[5:0];
  assign rs      = ir_q[25:21];
  assign rt      = ir_q[20:16];
  assign rd      = ir_q[15:11];
  assign sa      = ir_q[10:6];
  assign zext    = {16'd0, ir_q[15:0]};
  assign sext    = {{16{ir_q[15]}}, ir_q[15:0]};
  assign br_tgt  = pc4_q + {sext[29:0], 2'b00};
  assign j_tgt   = {pc4_q[31:28], ir_q[25:0], 2'b00};
  assign ld_wide = 32'(in_s.load_address);

  // Register read value, masked by valid bit and register zero;
  // rs data arrives in the rs read step, rt data in the rt read step
  always_comb begin
    rd_idx = (state_q == S_RDB) ? rt : rs;
    rd_val = rf_rdata;
    if ((rd_idx == 5'd0) || !rf_vld_q[rd_idx]) begin
      rd_val = '0;
    end
  end

  // Execute-stage control
  always_comb begin
    alu_op = rie_pkg::ALU_ADD;
    alu_b  = b_q;
    wr     = 1'b0;
    wi     = rt;
    known  = 1'b1;
    is_lw  = 1'b0;
    is_sw  = 1'b0;
    pc_d   = pc4_q;
    case (op)
      rie_pkg::OP_RTYPE: begin
        wr = 1'b1;
        wi = rd;
        case (fn)
          rie_pkg::FN_ADD, rie_pkg::FN_ADDU: alu_op = rie_pkg::ALU_ADD;
          rie_pkg::FN_SUB, rie_pkg::FN_SUBU: alu_op = rie_pkg::ALU_SUB;
          rie_pkg::FN_AND:  alu_op = rie_pkg::ALU_AND;
          rie_pkg::FN_OR:   alu_op = rie_pkg::ALU_OR;
          rie_pkg::FN_XOR:  alu_op = rie_pkg::ALU_XOR;
          rie_pkg::FN_NOR:  alu_op = rie_pkg::ALU_NOR;
          rie_pkg::FN_SLT:  alu_op = rie_pkg::ALU_SLT;
          rie_pkg::FN_SLTU: alu_op = rie_pkg::ALU_SLTU;
          rie_pkg::FN_SLL:  alu_op = rie_pkg::ALU_SLL;
          rie_pkg::FN_SRL:  alu_op = rie_pkg::ALU_SRL;
          rie_pkg::FN_JR: begin
            wr   = 1'b0;
            pc_d = a_q;
          end
          default: begin
            wr    = 1'b0;
            known = 1'b0;
          end
        endcase
      end
      rie_pkg::OP_ADDI, rie_pkg::OP_ADDIU: begin
        wr = 1'b1; alu_b = sext;
      end
      rie_pkg::OP_ANDI: begin
        wr = 1'b1; alu_op = rie_pkg::ALU_AND; alu_b = zext;
      end
      rie_pkg::OP_ORI: begin
        wr = 1'b1; alu_op = rie_pkg::ALU_OR; alu_b = zext;
      end
      rie_pkg::OP_XORI: begin
        wr = 1'b1; alu_op = rie_pkg::ALU_XOR; alu_b = zext;
      end
      rie_pkg::OP_LUI: begin
        wr = 1'b1; alu_op = rie_pkg::ALU_LUI; alu_b = zext;
      end
      rie_pkg::OP_SLTI: begin
        wr = 1'b1; alu_op = rie_pkg::ALU_SLT; alu_b = sext;
      end
      rie_pkg::OP_SLTIU: begin
        wr = 1'b1; alu_op = rie_pkg::ALU_SLTU; alu_b = sext;
      end
      rie_pkg::OP_LW: begin
        wr = 1'b1; is_lw = 1'b1; alu_b = sext;
      end
      rie_pkg::OP_SW: begin
        is_sw = 1'b1; alu_b = sext;
      end
      rie_pkg::OP_BEQ: begin
        alu_op = rie_pkg::ALU_SUB;
        if (alu_zero) begin
          pc_d = br_tgt;
        end
      end
      rie_pkg::OP_BNE: begin
        alu_op = rie_pkg::ALU_SUB;
        if (!alu_zero) begin
          pc_d = br_tgt;
        end
      end
      rie_pkg::OP_J: pc_d = j_tgt;
      rie_pkg::OP_JAL: begin
        wr   = 1'b1;
        wi   = 5'd31;
        pc_d = j_tgt;
      end
      default: known = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pc4_d     = pc4_q;
    ir_d      = ir_q;
    a_d       = a_q;
    b_d       = b_q;
    rf_vld_d  = rf_vld_q;
    res_d     = res_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    mem_we    = 1'b0;
    mem_waddr = rie_pkg::word_of(pc_q);
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rie_pkg::word_of(pc_q);
    rf_we     = 1'b0;
    rf_waddr  = wi;
    rf_wdata  = alu_y;
    rf_re     = 1'b0;
    rf_raddr  = rs;
    in_s.ready = (state_q == S_IDLE);

    // Drop the output word once taken
    if (out_vld_q && out_s.ready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + {{(rie_pkg::MEM_AW-1){1'b0}}, 1'b1};
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_s.valid) begin
          res_d         = '0;
          res_d.next_pc = pc_q;
          state_d       = S_OUT;
          case (in_s.opcode)
            rie_pkg::CMD_STEP: begin
              mem_re  = 1'b1;
              pc4_d   = pc_q + 32'd4;
              state_d = S_FETCH;
            end
            rie_pkg::CMD_LOAD: begin
              mem_we            = 1'b1;
              mem_waddr         = ld_wide[rie_pkg::MEM_AW-1:0];
              mem_wdata         = in_s.load_data;
              res_d.status      = rie_pkg::ST_LOADED;
              res_d.mem_written = 1'b1;
              res_d.mem_index   = rie_pkg::index_out(ld_wide[rie_pkg::MEM_AW-1:0]);
              res_d.mem_value   = in_s.load_data;
            end
            rie_pkg::CMD_RESTART: begin
              rf_vld_d      = '0;
              res_d.status  = rie_pkg::ST_RESTART;
              res_d.next_pc = start_q;
            end
            default: res_d.status = rie_pkg::ST_UNKNOWN;
          endcase
        end
      end
      S_FETCH: begin
        ir_d     = mem_rdata;
        rf_re    = 1'b1;
        rf_raddr = mem_rdata[25:21];
        state_d  = S_RDA;
      end
      S_RDA: begin
        rf_raddr = rt;
        a_d      = rd_val;
        rf_re    = 1'b1;
        state_d  = S_RDB;
      end
      S_RDB: begin
        b_d     = rd_val;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        res_d                = '0;
        res_d.instruction    = ir_q;
        res_d.next_pc        = pc_d;
        res_d.breakpoint_hit = (pc_d == brk_q);
        res_d.status         = known ? rie_pkg::ST_EXEC : rie_pkg::ST_UNKNOWN;
        if (wr && (wi != 5'd0)) begin
          res_d.reg_written = 1'b1;
          res_d.reg_index   = wi;
          res_d.reg_value   = (op == rie_pkg::OP_JAL) ? pc4_q : alu_y;
        end
        if (is_sw) begin
          mem_we            = 1'b1;
          mem_waddr         = rie_pkg::word_of(alu_y);
          mem_wdata         = b_q;
          res_d.mem_written = 1'b1;
          res_d.mem_index   = rie_pkg::index_out(rie_pkg::word_of(alu_y));
          res_d.mem_value   = b_q;
        end
        if (is_lw) begin
          mem_re    = 1'b1;
          mem_raddr = rie_pkg::word_of(alu_y);
          state_d   = S_LWB;
        end else begin
          rf_we    = wr && (wi != 5'd0);
          rf_wdata = res_d.reg_value;
          if (rf_we) begin
            rf_vld_d[wi] = 1'b1;
          end
          state_d = S_OUT;
        end
      end
      S_LWB: begin
        rf_waddr = res_q.reg_index;
        rf_wdata = mem_rdata;
        rf_we    = res_q.reg_written;
        if (res_q.reg_written) begin
          res_d.reg_value             = mem_rdata;
          rf_vld_d[res_q.reg_index]   = 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_vld_q || out_s.ready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      pc_q      <= '0;
      rf_vld_q  <= '0;
      out_vld_q <= 1'b0;
      start_q   <= '0;
      brk_q     <= '1;
    end else begin
      clr_q     <= clr_d;
      rf_vld_q  <= rf_vld_d;
      out_vld_q <= out_vld_d;
      state_q   <= state_d;
      if ((state_q == S_EXEC) || (state_q == S_IDLE && in_s.valid)) begin
        pc_q <= (state_q == S_EXEC) ? pc_d : res_d.next_pc;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START: start_q <= cfg_data_i;
          CFG_BREAK: brk_q   <= cfg_data_i;
          default:   start_q <= start_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pc4_q <= pc4_d;
    ir_q  <= ir_d;
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  // Drive the result channel
  assign out_s.valid          = out_vld_q;
  assign out_s.status         = out_q.status;
  assign out_s.instruction    = out_q.instruction;
  assign out_s.next_pc        = out_q.next_pc;
  assign out_s.reg_written    = out_q.reg_written;
  assign out_s.reg_index      = out_q.reg_index;
  assign out_s.reg_value      = out_q.reg_value;
  assign out_s.mem_written    = out_q.mem_written;
  assign out_s.mem_index      = out_q.mem_index;
  assign out_s.mem_value      = out_q.mem_value;
  assign out_s.breakpoint_hit = out_q.breakpoint_hit;

endmodule

@@ tb/sv/risc_integer_subset_executor_tb.sv @@
// Testbench for the integer subset executor: drives command words, predicts
// every result word and checks it as a whole against the prediction.
// Depends on rie_pkg, rie_in_if, rie_out_if and the block itself.
`timescale 1ns / 1ps

module risc_integer_subset_executor_tb;

  // Expected results of the executor, kept in order of acceptance
  class exec_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] pc;
    logic [31:0] mem [rie_pkg::MEM_WORDS];
    logic [31:0] start_pc;
    logic [31:0] break_pc;
    rie_pkg::result_t pending [$];

    function void clear_all();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      pc       = '0;
      start_pc = '0;
      break_pc = '1;
    endfunction

    function logic [31:0] rreg(logic [4:0] i);
      return (i == 5'd0) ? 32'd0 : regs[i];
    endfunction

    function logic [9:0] widx(logic [31:0] a);
      logic [31:0] w;
      w = a >> 2;
      return w[9:0];
    endfunction

    // Note an accepted command and work out its result word
    function void note_command(logic [1:0] cmd, logic [9:0] la, logic [31:0] ld);
      rie_pkg::result_t r;
      logic [31:0] ir, a, b, sx, imm;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd, sa, wi;
      logic        wr, known;
      logic [31:0] wv;
      r = '0;
      if (cmd == rie_pkg::CMD_LOAD) begin
        mem[la] = ld;
        r.status = rie_pkg::ST_LOADED; r.next_pc = pc;
        r.mem_written = 1'b1; r.mem_index = la; r.mem_value = ld;
      end else if (cmd == rie_pkg::CMD_RESTART) begin
        foreach (regs[i]) regs[i] = '0;
        pc = start_pc;
        r.status = rie_pkg::ST_RESTART; r.next_pc = pc;
      end else if (cmd == rie_pkg::CMD_NONE) begin
        r.status = rie_pkg::ST_UNKNOWN; r.next_pc = pc;
      end else begin
        ir = mem[widx(pc)];
        op = ir[31:26]; fn = ir[5:0];
        rs = ir[25:21]; rt = ir[20:16]; rd = ir[15:11]; sa = ir[10:6];
        imm = {16'd0, ir[15:0]};
        sx = {{16{ir[15]}}, ir[15:0]};
        a = rreg(rs); b = rreg(rt);
        pc = pc + 32'd4;
        wr = 1'b0; wi = '0; wv = '0; known = 1'b1;
        case (op)
          rie_pkg::OP_RTYPE: begin
            wr = 1'b1; wi = rd;
            case (fn)
              rie_pkg::FN_ADD, rie_pkg::FN_ADDU: wv = a + b;
              rie_pkg::FN_SUB, rie_pkg::FN_SUBU: wv = a - b;
              rie_pkg::FN_AND: wv = a & b;
              rie_pkg::FN_OR:  wv = a | b;
              rie_pkg::FN_XOR: wv = a ^ b;
              rie_pkg::FN_NOR: wv = ~(a | b);
              rie_pkg::FN_SLT:  wv = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
              rie_pkg::FN_SLTU: wv = (a < b) ? 32'd1 : 32'd0;
              rie_pkg::FN_SLL: wv = b << sa;
              rie_pkg::FN_SRL: wv = b >> sa;
              rie_pkg::FN_JR: begin
                wr = 1'b0; pc = a;
              end
              default: begin
                wr = 1'b0; known = 1'b0;
              end
            endcase
          end
          rie_pkg::OP_ADDI, rie_pkg::OP_ADDIU: begin wr = 1'b1; wi = rt; wv = a + sx; end
          rie_pkg::OP_ANDI: begin wr = 1'b1; wi = rt; wv = a & imm; end
          rie_pkg::OP_ORI:  begin wr = 1'b1; wi = rt; wv = a | imm; end
          rie_pkg::OP_XORI: begin wr = 1'b1; wi = rt; wv = a ^ imm; end
          rie_pkg::OP_LUI:  begin wr = 1'b1; wi = rt; wv = imm << 16; end
          rie_pkg::OP_SLTI: begin
            wr = 1'b1; wi = rt; wv = ($signed(a) < $signed(sx)) ? 32'd1 : 32'd0;
          end
          rie_pkg::OP_SLTIU: begin wr = 1'b1; wi = rt; wv = (a < sx) ? 32'd1 : 32'd0; end
          rie_pkg::OP_LW: begin wr = 1'b1; wi = rt; wv = mem[widx(a + sx)]; end
          rie_pkg::OP_SW: begin
            r.mem_written = 1'b1; r.mem_index = widx(a + sx); r.mem_value = b;
            mem[widx(a + sx)] = b;
          end
          rie_pkg::OP_BEQ: if (a == b) pc = pc + (sx << 2);
          rie_pkg::OP_BNE: if (a != b) pc = pc + (sx << 2);
          rie_pkg::OP_J: pc = {pc[31:28], ir[25:0], 2'b00};
          rie_pkg::OP_JAL: begin
            wr = 1'b1; wi = 5'd31; wv = pc;
            pc = {pc[31:28], ir[25:0], 2'b00};
          end
          default: known = 1'b0;
        endcase
        // drop writes to register zero
        if (wr && wi == 5'd0) wr = 1'b0;
        if (wr) regs[wi] = wv;
        else begin
          wi = '0; wv = '0;
        end
        r.status = known ? rie_pkg::ST_EXEC : rie_pkg::ST_UNKNOWN;
        r.instruction = ir; r.next_pc = pc;
        r.reg_written = wr; r.reg_index = wi; r.reg_value = wv;
        r.breakpoint_hit = (pc == break_pc);
      end
      pending.push_back(r);
    endfunction

    // Compare a result word with the oldest expectation; return mismatches
    function int check_result(rie_pkg::result_t got, output rie_pkg::result_t want);
      if (pending.size() == 0) begin
        want = '0;
        return -1;
      end
      want = pending.pop_front();
      return (got === want) ? 0 : 1;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;

  rie_in_if  in_ch ();
  rie_out_if out_ch ();

  risc_integer_subset_executor i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_ch.sink),
    .out_s      (out_ch.source),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  exec_scoreboard sb;
  int  fail_count;
  int  idle_cycles;
  bit  quiet;        // no idling in the last part
  bit  long_hold;    // receiver holds off for a long stretch

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  task automatic report_mismatch(string what, rie_pkg::result_t got,
                                 rie_pkg::result_t want);
    $display("MISMATCH %s: got %h want %h", what, got, want);
    fail_count++;
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Check every accepted result word
  always @(posedge clk_i) begin
    rie_pkg::result_t got, want;
    int      res;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.instruction, out_ch.next_pc, out_ch.reg_written,
              out_ch.reg_index, out_ch.reg_value, out_ch.mem_written, out_ch.mem_index,
              out_ch.mem_value, out_ch.breakpoint_hit};
      res = sb.check_result(got, want);
      if (res < 0) report_mismatch("unexpected word", got, want);
      else if (res > 0) report_mismatch("field", got, want);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one command word and wait until it is taken
  task automatic send_word(logic [1:0] cmd, logic [9:0] la, logic [31:0] ld);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= cmd;
    in_ch.load_address <= la;
    in_ch.load_data <= ld;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_command(cmd, la, ld);
  endtask

  task automatic load_word(logic [9:0] la, logic [31:0] ld);
    send_word(rie_pkg::CMD_LOAD, la, ld);
  endtask

  // Drop valid, wait until all results are in, then settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == 1'b0) sb.start_pc = val; else sb.break_pc = val;
  endtask

  function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                         logic [4:0] sa, logic [5:0] fn);
    return {rie_pkg::OP_RTYPE, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                         logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Random instruction, mostly known kinds with small offsets
  function automatic logic [31:0] rand_instr();
    logic [5:0] ops [15] = '{rie_pkg::OP_ADDI, rie_pkg::OP_ADDIU, rie_pkg::OP_SLTI,
                             rie_pkg::OP_SLTIU, rie_pkg::OP_ANDI, rie_pkg::OP_ORI,
                             rie_pkg::OP_XORI, rie_pkg::OP_LUI, rie_pkg::OP_LW,
                             rie_pkg::OP_SW, rie_pkg::OP_BEQ, rie_pkg::OP_BNE,
                             rie_pkg::OP_J, rie_pkg::OP_JAL, rie_pkg::OP_RTYPE};
    logic [5:0] fns [13] = '{rie_pkg::FN_SLL, rie_pkg::FN_SRL, rie_pkg::FN_JR,
                             rie_pkg::FN_ADD, rie_pkg::FN_ADDU, rie_pkg::FN_SUB,
                             rie_pkg::FN_SUBU, rie_pkg::FN_AND, rie_pkg::FN_OR,
                             rie_pkg::FN_XOR, rie_pkg::FN_NOR, rie_pkg::FN_SLT,
                             rie_pkg::FN_SLTU};
    logic [31:0] w;
    logic [5:0]  op;
    int          off;
    w = $urandom();
    case ($urandom_range(0, 9))
      0: return w;
      1, 2, 3: return {rie_pkg::OP_RTYPE, w[25:6], fns[$urandom_range(0, 12)]};
      default: begin
        op = ops[$urandom_range(0, 14)];
        if (op == rie_pkg::OP_BEQ || op == rie_pkg::OP_BNE) begin
          off = int'($urandom_range(0, 8)) - 4;
          w[15:0] = off[15:0];
        end
        if (op == rie_pkg::OP_J || op == rie_pkg::OP_JAL) begin
          w[25:0] = 26'($urandom_range(0, 255));
        end
        if (op == rie_pkg::OP_RTYPE) w[5:0] = fns[$urandom_range(0, 12)];
        return {op, w[25:0]};
      end
    endcase
  endfunction

  initial begin
    int n;
    logic [31:0] ld;
    sb = new();
    sb.clear_all();
    fail_count = 0; idle_cycles = 0; quiet = 0; long_hold = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    in_ch.valid = 1'b0; in_ch.opcode = rie_pkg::CMD_STEP; in_ch.load_address = '0;
    in_ch.load_data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a small program with several kinds and edge values
    load_word(10'd0,  i_word(rie_pkg::OP_ADDI, 5'd0, 5'd1, 16'hffff));
    load_word(10'd1,  i_word(rie_pkg::OP_LUI, 5'd0, 5'd2, 16'h8000));
    load_word(10'd2,  r_word(5'd1, 5'd2, 5'd3, 5'd0, rie_pkg::FN_SLT));
    load_word(10'd3,  r_word(5'd1, 5'd2, 5'd0, 5'd0, rie_pkg::FN_SLTU));
    load_word(10'd4,  i_word(rie_pkg::OP_ORI, 5'd1, 5'd4, 16'hffff));
    load_word(10'd5,  r_word(5'd31, 5'd1, 5'd5, 5'd31, rie_pkg::FN_SLL));
    load_word(10'd6,  r_word(5'd0, 5'd1, 5'd6, 5'd31, rie_pkg::FN_SRL));
    load_word(10'd7,  i_word(rie_pkg::OP_SW, 5'd0, 5'd1, 16'h0fff));
    load_word(10'd8,  i_word(rie_pkg::OP_LW, 5'd1, 5'd7, 16'h0ffc));
    load_word(10'd9,  32'hfc00_0000);
    load_word(10'd10, r_word(5'd0, 5'd0, 5'd1, 5'd0, 6'd63));
    load_word(10'd11, i_word(rie_pkg::OP_BNE, 5'd1, 5'd0, 16'h0001));
    load_word(10'd13, {rie_pkg::OP_JAL, 26'd20});
    load_word(10'd20, i_word(rie_pkg::OP_SLTIU, 5'd0, 5'd8, 16'h8000));
    load_word(10'd21, r_word(5'd31, 5'd0, 5'd0, 5'd0, rie_pkg::FN_JR));
    load_word(10'd1023, 32'hffff_ffff);
    drain();
    write_reg(1'b1, 32'd84);
    for (int i = 0; i < 16; i++) send_word(rie_pkg::CMD_STEP, '0, '0);
    send_word(rie_pkg::CMD_NONE, 10'h3ff, '1);
    drain();
    write_reg(1'b0, 32'hffff_fffc);
    send_word(rie_pkg::CMD_RESTART, '0, '0);
    send_word(rie_pkg::CMD_STEP, '0, '0);
    drain();

    // random phases with several register settings
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(1'b0, (ph == 3) ? 32'd0 : ($urandom() & 32'h0000_0ffc));
      write_reg(1'b1, (ph == 0) ? 32'hffff_ffff : ($urandom_range(0, 63) << 2));
      if (ph == 1) begin
        long_hold = 1'b1;
      end
      if (ph == 3) quiet = 1'b1;
      send_word(rie_pkg::CMD_RESTART, '0, '0);
      // fill a small program window with random instructions
      for (int i = 0; i < 64; i++) load_word(i[9:0], rand_instr());
      n = 0;
      while (n < 140) begin
        case ($urandom_range(0, 19))
          0: send_word(rie_pkg::CMD_RESTART, '0, '0);
          1: send_word(rie_pkg::CMD_NONE, 10'($urandom()), $urandom());
          2, 3: begin
            ld = $urandom();
            load_word(10'($urandom()), ($urandom_range(0, 1)) ? rand_instr() : ld);
          end
          default: send_word(rie_pkg::CMD_STEP, 10'($urandom()), $urandom());
        endcase
        n++;
      end
      drain();
    end

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ risc_integer_subset_executor.f @@
rtl/rie_pkg.sv
rtl/rie_in_if.sv
rtl/rie_out_if.sv
rtl/rie_ram.sv
rtl/rie_alu.sv
rtl/risc_integer_subset_executor.sv
tb/sv/risc_integer_subset_executor_tb.sv
